// ----- rtl/ssbd_pkg.sv -----
// Shared types, constants and the payload position function for the start/stop bit deframer.
package ssbd_pkg;

	localparam int unsigned FRAME_LEN = 10;
	localparam int unsigned STOP_POS  = 9;
	localparam int unsigned BYTE_BITS = 8;
	localparam int unsigned TOP_BIT   = 7;

	localparam logic [3:0] FULL_COUNT = 4'(BYTE_BITS);

	typedef struct packed {
		logic [7:0] data_byte;
		logic [3:0] valid_bits;
		logic       final_byte;
	} result_t;

	typedef struct packed {
		result_t    res0;
		result_t    res1;
		logic [1:0] nres;
		logic [3:0] phase;
		logic [7:0] gather;
		logic [2:0] count;
	} step_out_t;

	// Marks which of the eight raw bits, first bit in bit 7, carry payload.
	function automatic logic [7:0] payload_mask(input logic [3:0] phase);
		logic [7:0] mask;
		logic [4:0] ph;
		mask = '0;
		for (int b = 0; b < 8; b++) begin
			ph = 5'(phase) + 5'(b);
			if (ph >= 5'(FRAME_LEN)) begin
				ph = ph - 5'(FRAME_LEN);
			end
			mask[TOP_BIT - b] = (ph != 5'd0) && (ph != 5'(STOP_POS));
		end
		return mask;
	endfunction

endpackage

// ----- rtl/ssbd_step.sv -----
// Combinational deframing of one raw byte against the current frame phase and partial byte.
module ssbd_step (
	input  logic [3:0]         phase,
	input  logic [7:0]         gather,
	input  logic [2:0]         count,
	input  logic [7:0]         raw_byte,
	input  logic               end_of_buffer,
	output ssbd_pkg::step_out_t step_out
);
	import ssbd_pkg::*;

	logic [7:0]  mask;
	logic [7:0]  comp;
	logic [3:0]  npay;
	logic [15:0] acc;
	logic [3:0]  total;
	logic        full;
	logic [7:0]  rem_byte;
	logic [2:0]  rem_cnt;
	logic [3:0]  phase_nx;
	result_t     r_full;
	result_t     r_flush;

	assign mask = payload_mask(phase);

	always_comb begin
		comp = '0;
		npay = '0;
		for (int b = 0; b < 8; b++) begin
			if (mask[TOP_BIT - b]) begin
				comp[npay[2:0]] = raw_byte[TOP_BIT - b];
				npay = npay + 4'd1;
			end
		end
	end

	assign acc      = {8'd0, gather} | ({8'd0, comp} << count);
	assign total    = {1'b0, count} + npay;
	assign full     = total[3];
	assign rem_byte = full ? acc[15:8] : acc[7:0];
	assign rem_cnt  = total[2:0];
	assign phase_nx = (phase >= 4'd2) ? phase - 4'd2 : phase + 4'd8;

	assign r_full  = '{data_byte: acc[7:0], valid_bits: FULL_COUNT, final_byte: 1'b0};
	assign r_flush = '{data_byte: rem_byte, valid_bits: {1'b0, rem_cnt}, final_byte: 1'b1};

	always_comb begin
		step_out.res0   = r_full;
		step_out.res1   = r_flush;
		step_out.nres   = {1'b0, full};
		step_out.phase  = phase_nx;
		step_out.gather = rem_byte;
		step_out.count  = rem_cnt;
		if (end_of_buffer) begin
			step_out.phase  = '0;
			step_out.gather = '0;
			step_out.count  = '0;
			if (rem_cnt != 3'd0) begin
				if (full) begin
					step_out.nres = 2'd2;
				end else begin
					step_out.res0 = r_flush;
					step_out.nres = 2'd1;
				end
			end else begin
				step_out.res0.final_byte = 1'b1;
				step_out.nres            = 2'd1;
			end
		end
	end

endmodule

// ----- rtl/start_stop_bit_deframer.sv -----
// Top level of the start/stop bit deframer: input register, step logic and result buffer.
// The block takes one raw byte per clock cycle; the raw byte is held in the input register, and
// its decoded bytes are registered into the result buffer. Every raw byte yields zero, one or two
// results; a raw byte that both completes a byte and flushes a partial byte at the end of a buffer
// yields two, and the two-entry result buffer drains them at one result per cycle, so input stalls
// only when the output side stalls or when a second result is still waiting for its slot. The frame
// phase and partial byte live in registers updated as each raw byte leaves the input register.
module start_stop_bit_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] raw_byte,
	input  logic       end_of_buffer,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_byte,
	output logic [3:0] valid_bits,
	output logic       final_byte
);
	import ssbd_pkg::*;

	logic       valid_s1;
	logic [7:0] raw_s1;
	logic       eob_s1;
	logic [3:0] phase_q;
	logic [7:0] gather_q;
	logic [2:0] count_q;
	step_out_t  step_out;
	result_t    slot_q [2];
	result_t    slot_d [2];
	logic [1:0] fill_q;
	logic [1:0] fill_d;
	logic [1:0] base;
	logic [1:0] free;
	logic [1:0] push;
	logic       pop;
	logic       adv;
	logic       accept;

	ssbd_step u_step (
		.phase         (phase_q),
		.gather        (gather_q),
		.count         (count_q),
		.raw_byte      (raw_s1),
		.end_of_buffer (eob_s1),
		.step_out      (step_out)
	);

	assign pop      = (fill_q != 2'd0) && !out_stall;
	assign free     = 2'd2 - fill_q + {1'b0, pop};
	assign adv      = valid_s1 && (free >= step_out.nres);
	assign push     = adv ? step_out.nres : 2'd0;
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || in_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_s1 <= raw_byte;
			eob_s1 <= end_of_buffer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			gather_q <= '0;
			count_q  <= '0;
		end else if (adv) begin
			phase_q  <= step_out.phase;
			gather_q <= step_out.gather;
			count_q  <= step_out.count;
		end
	end

	always_comb begin
		slot_d[0] = slot_q[0];
		slot_d[1] = slot_q[1];
		if (pop) begin
			slot_d[0] = slot_q[1];
		end
		base = fill_q - {1'b0, pop};
		if (push != 2'd0) begin
			slot_d[base[0]] = step_out.res0;
		end
		if (push == 2'd2) begin
			slot_d[1] = step_out.res1;
		end
		fill_d = base + push;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		slot_q[0] <= slot_d[0];
		slot_q[1] <= slot_d[1];
	end

	assign out_valid  = fill_q != 2'd0;
	assign data_byte  = slot_q[0].data_byte;
	assign valid_bits = slot_q[0].valid_bits;
	assign final_byte = slot_q[0].final_byte;

endmodule

// ----- rtl/ssbd_checker.sv -----
// Port-level assertions for the start/stop bit deframer and their bind to the top level.
module ssbd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] data_byte,
	input logic [3:0] valid_bits,
	input logic       final_byte
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(valid_bits)
			&& $stable(final_byte))
		else $error("Stalled result item changed.");

	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (valid_bits >= 4'd1) && (valid_bits <= 4'd8))
		else $error("Result item has an invalid bit count.");

	a_partial_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (valid_bits != 4'd8) |-> final_byte)
		else $error("Partial byte is not marked as final.");

	a_partial_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (valid_bits != 4'd8) |-> ((data_byte >> valid_bits) == 8'd0))
		else $error("Partial byte has unfilled bits set.");

endmodule

bind start_stop_bit_deframer ssbd_checker u_ssbd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.data_byte  (data_byte),
	.valid_bits (valid_bits),
	.final_byte (final_byte)
);
